@@ design/dtfe_pkg.sv @@
// Shared types, codes and helper functions for the date and time field editor.
`timescale 1ns / 1ps

package dtfe_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_UNITS  = 2'd1,
        KIND_TENS   = 2'd2,
        KIND_ACCEPT = 2'd3
    } t_kind;

    localparam logic [2:0] FIELD_YEAR    = 3'd0;
    localparam logic [2:0] FIELD_MONTH   = 3'd1;
    localparam logic [2:0] FIELD_DAY     = 3'd2;
    localparam logic [2:0] FIELD_HOURS   = 3'd3;
    localparam logic [2:0] FIELD_MINUTES = 3'd4;
    localparam logic [2:0] FIELD_SECONDS = 3'd5;

    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOURS_MAX  = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
        logic [5:0] load_seconds;
    } t_item;

    typedef struct packed {
        logic [2:0] field;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_state;

    // Length of the month, with the leap day in February of every fourth year.
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Last decimal digit of a value below 128, by reciprocal multiplication.
    function automatic logic [6:0] last_digit(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  tens;
        prod = {8'd0, v} * 15'd205;
        q    = prod[14:11];
        tens = {q, 3'd0} + {2'd0, q, 1'b0};
        return v - tens;
    endfunction

    // Adds ten and keeps only the last digit when the sum passes the top.
    function automatic logic [6:0] add_ten(input logic [6:0] v, input logic [6:0] top);
        logic [6:0] s;
        s = v + 7'd10;
        return (s > top) ? last_digit(s) : s;
    endfunction

endpackage

@@ design/dtfe_update.sv @@
// Next-state logic of the editor for one key event.
`timescale 1ns / 1ps

module dtfe_update (
    input  dtfe_pkg::t_item  i_item,
    input  dtfe_pkg::t_state i_state,
    output dtfe_pkg::t_state o_state,
    output logic             o_commit
);

    logic [4:0] dim;
    logic [5:0] day_inc;
    logic [6:0] day_ten;

    assign dim     = dtfe_pkg::days_in_month(i_state.month, i_state.year);
    assign day_inc = {1'b0, i_state.day} + 6'd1;
    assign day_ten = dtfe_pkg::add_ten({2'd0, i_state.day}, {2'd0, dim});

    always_comb begin
        o_state  = i_state;
        o_commit = 1'b0;
        case (i_item.kind)
            dtfe_pkg::KIND_LOAD: begin
                o_state.field   = dtfe_pkg::FIELD_YEAR;
                o_state.year    = (i_item.load_year > dtfe_pkg::YEAR_MAX) ?
                                  7'd0 : i_item.load_year;
                o_state.month   = (i_item.load_month == 4'd0 ||
                                   i_item.load_month > dtfe_pkg::MONTH_MAX) ?
                                  4'd1 : i_item.load_month;
                o_state.day     = (i_item.load_day == 5'd0) ? 5'd1 : i_item.load_day;
                o_state.hours   = (i_item.load_hours > dtfe_pkg::HOURS_MAX) ?
                                  5'd0 : i_item.load_hours;
                o_state.minutes = (i_item.load_minutes > dtfe_pkg::MINSEC_MAX) ?
                                  6'd0 : i_item.load_minutes;
                o_state.seconds = (i_item.load_seconds > dtfe_pkg::MINSEC_MAX) ?
                                  6'd0 : i_item.load_seconds;
            end
            dtfe_pkg::KIND_UNITS: begin
                case (i_state.field)
                    dtfe_pkg::FIELD_YEAR:
                        o_state.year = (i_state.year >= dtfe_pkg::YEAR_MAX) ?
                                       7'd0 : i_state.year + 7'd1;
                    dtfe_pkg::FIELD_MONTH:
                        o_state.month = (i_state.month >= dtfe_pkg::MONTH_MAX) ?
                                        4'd1 : i_state.month + 4'd1;
                    dtfe_pkg::FIELD_DAY:
                        o_state.day = (day_inc > {1'b0, dim}) ? 5'd1 : day_inc[4:0];
                    dtfe_pkg::FIELD_HOURS:
                        o_state.hours = (i_state.hours >= dtfe_pkg::HOURS_MAX) ?
                                        5'd0 : i_state.hours + 5'd1;
                    dtfe_pkg::FIELD_MINUTES:
                        o_state.minutes = (i_state.minutes >= dtfe_pkg::MINSEC_MAX) ?
                                          6'd0 : i_state.minutes + 6'd1;
                    dtfe_pkg::FIELD_SECONDS:
                        o_state.seconds = (i_state.seconds >= dtfe_pkg::MINSEC_MAX) ?
                                          6'd0 : i_state.seconds + 6'd1;
                    default: ;
                endcase
            end
            dtfe_pkg::KIND_TENS: begin
                case (i_state.field)
                    dtfe_pkg::FIELD_YEAR:
                        o_state.year = dtfe_pkg::add_ten(i_state.year, dtfe_pkg::YEAR_MAX);
                    dtfe_pkg::FIELD_MONTH: begin
                        if (i_state.month > 4'd10) begin
                            o_state.month = i_state.month - 4'd10;
                        end else if (i_state.month < 4'd3) begin
                            o_state.month = i_state.month + 4'd10;
                        end
                    end
                    dtfe_pkg::FIELD_DAY:
                        o_state.day = (day_ten == 7'd0) ? 5'd1 : day_ten[4:0];
                    dtfe_pkg::FIELD_HOURS:
                        o_state.hours = 5'(dtfe_pkg::add_ten({2'd0, i_state.hours},
                                                             {2'd0, dtfe_pkg::HOURS_MAX}));
                    dtfe_pkg::FIELD_MINUTES:
                        o_state.minutes = 6'(dtfe_pkg::add_ten({1'b0, i_state.minutes},
                                                               {1'b0, dtfe_pkg::MINSEC_MAX}));
                    dtfe_pkg::FIELD_SECONDS:
                        o_state.seconds = 6'(dtfe_pkg::add_ten({1'b0, i_state.seconds},
                                                               {1'b0, dtfe_pkg::MINSEC_MAX}));
                    default: ;
                endcase
            end
            default: begin
                if (i_state.field >= dtfe_pkg::FIELD_SECONDS) begin
                    o_state.field = dtfe_pkg::FIELD_YEAR;
                    o_commit      = 1'b1;
                end else begin
                    o_state.field = i_state.field + 3'd1;
                end
            end
        endcase
    end

endmodule

@@ design/date_time_field_editor.sv @@
// Top level of the date and time field editor: input register, state and result register.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    i_kind, i_load_*
//   out       output     o_out_valid / i_out_ready  o_field_index, o_cur_*, o_commit
//
// Each beat is held in the input register while the update logic works on it, and
// its result is then registered in the state register, and one beat is taken per
// cycle while the output is drained. The edit state lives in one register set that
// is written as an item leaves the input register. Reset clears the valid flags and
// sets the state to year 0, month 1, day 1, 00:00:00 with the year field selected.
// A stall at the output holds the result register and then the input register.
`timescale 1ns / 1ps

module date_time_field_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_load_year,
    input  logic [3:0] i_load_month,
    input  logic [4:0] i_load_day,
    input  logic [4:0] i_load_hours,
    input  logic [5:0] i_load_minutes,
    input  logic [5:0] i_load_seconds,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_field_index,
    output logic [6:0] o_cur_year,
    output logic [3:0] o_cur_month,
    output logic [4:0] o_cur_day,
    output logic [4:0] o_cur_hours,
    output logic [5:0] o_cur_minutes,
    output logic [5:0] o_cur_seconds,
    output logic       o_commit
);

    logic             r_in_valid;
    dtfe_pkg::t_item  r_item;
    dtfe_pkg::t_state r_state;
    logic             r_out_valid;
    logic             r_commit;
    dtfe_pkg::t_state n_state;
    logic             n_commit;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    dtfe_update u_update (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_commit(n_commit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.kind         <= dtfe_pkg::t_kind'(i_kind);
            r_item.load_year    <= i_load_year;
            r_item.load_month   <= i_load_month;
            r_item.load_day     <= i_load_day;
            r_item.load_hours   <= i_load_hours;
            r_item.load_minutes <= i_load_minutes;
            r_item.load_seconds <= i_load_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.field   <= dtfe_pkg::FIELD_YEAR;
            r_state.year    <= 7'd0;
            r_state.month   <= 4'd1;
            r_state.day     <= 5'd1;
            r_state.hours   <= 5'd0;
            r_state.minutes <= 6'd0;
            r_state.seconds <= 6'd0;
            r_out_valid     <= 1'b0;
            r_commit        <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
            r_commit    <= n_commit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_index = r_state.field;
    assign o_cur_year    = r_state.year;
    assign o_cur_month   = r_state.month;
    assign o_cur_day     = r_state.day;
    assign o_cur_hours   = r_state.hours;
    assign o_cur_minutes = r_state.minutes;
    assign o_cur_seconds = r_state.seconds;
    assign o_commit      = r_commit;

endmodule

@@ verif/dtfe_checker.sv @@
// Checker that predicts every result beat of the field editor and compares it field by field.
`timescale 1ns / 1ps

module dtfe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_load_year,
    input  logic [3:0] i_load_month,
    input  logic [4:0] i_load_day,
    input  logic [4:0] i_load_hours,
    input  logic [5:0] i_load_minutes,
    input  logic [5:0] i_load_seconds,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_field_index,
    input  logic [6:0] i_cur_year,
    input  logic [3:0] i_cur_month,
    input  logic [4:0] i_cur_day,
    input  logic [4:0] i_cur_hours,
    input  logic [5:0] i_cur_minutes,
    input  logic [5:0] i_cur_seconds,
    input  logic       i_commit,
    output int         o_errors,
    output int         o_pending
);

    typedef struct {
        logic [2:0] field;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       commit;
    } t_clock_view;

    logic [2:0] sel_field;
    logic [6:0] year_v;
    logic [3:0] month_v;
    logic [4:0] day_v;
    logic [4:0] hours_v;
    logic [5:0] minutes_v;
    logic [5:0] seconds_v;

    t_clock_view view_q[$];
    int          mismatches = 0;
    int          waiting = 0;

    assign o_errors  = mismatches;
    assign o_pending = waiting;

    function automatic int month_length();
        int len;
        case (month_v)
            4'd2:                    len = (year_v % 4 == 0) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 30;
            default:                 len = 31;
        endcase
        return len;
    endfunction

    function automatic int plus_ten(input int v, input int top);
        int s;
        s = v + 10;
        return (s > top) ? s % 10 : s;
    endfunction

    task automatic clear_clock();
        sel_field = dtfe_pkg::FIELD_YEAR;
        year_v    = 7'd0;
        month_v   = 4'd1;
        day_v     = 5'd1;
        hours_v   = 5'd0;
        minutes_v = 6'd0;
        seconds_v = 6'd0;
    endtask

    task automatic apply_key(output t_clock_view view);
        int   v;
        logic done;
        done = 1'b0;
        case (dtfe_pkg::t_kind'(i_kind))
            dtfe_pkg::KIND_LOAD: begin
                year_v    = (i_load_year > 99) ? 7'd0 : i_load_year;
                month_v   = (i_load_month < 1 || i_load_month > 12) ? 4'd1 : i_load_month;
                day_v     = (i_load_day < 1) ? 5'd1 : i_load_day;
                hours_v   = (i_load_hours > 23) ? 5'd0 : i_load_hours;
                minutes_v = (i_load_minutes > 59) ? 6'd0 : i_load_minutes;
                seconds_v = (i_load_seconds > 59) ? 6'd0 : i_load_seconds;
                sel_field = dtfe_pkg::FIELD_YEAR;
            end
            dtfe_pkg::KIND_UNITS: begin
                case (sel_field)
                    dtfe_pkg::FIELD_YEAR:
                        year_v = (year_v >= 99) ? 7'd0 : year_v + 7'd1;
                    dtfe_pkg::FIELD_MONTH:
                        month_v = (month_v >= 12) ? 4'd1 : month_v + 4'd1;
                    dtfe_pkg::FIELD_DAY: begin
                        v = day_v + 1;
                        day_v = (v > month_length()) ? 5'd1 : 5'(v);
                    end
                    dtfe_pkg::FIELD_HOURS:
                        hours_v = (hours_v >= 23) ? 5'd0 : hours_v + 5'd1;
                    dtfe_pkg::FIELD_MINUTES:
                        minutes_v = (minutes_v >= 59) ? 6'd0 : minutes_v + 6'd1;
                    dtfe_pkg::FIELD_SECONDS:
                        seconds_v = (seconds_v >= 59) ? 6'd0 : seconds_v + 6'd1;
                    default: ;
                endcase
            end
            dtfe_pkg::KIND_TENS: begin
                case (sel_field)
                    dtfe_pkg::FIELD_YEAR: year_v = 7'(plus_ten(year_v, 99));
                    dtfe_pkg::FIELD_MONTH: begin
                        if (month_v > 10) begin
                            month_v = month_v - 4'd10;
                        end else if (month_v < 3) begin
                            month_v = month_v + 4'd10;
                        end
                    end
                    dtfe_pkg::FIELD_DAY: begin
                        v = plus_ten(day_v, month_length());
                        day_v = (v == 0) ? 5'd1 : 5'(v);
                    end
                    dtfe_pkg::FIELD_HOURS:   hours_v = 5'(plus_ten(hours_v, 23));
                    dtfe_pkg::FIELD_MINUTES: minutes_v = 6'(plus_ten(minutes_v, 59));
                    dtfe_pkg::FIELD_SECONDS: seconds_v = 6'(plus_ten(seconds_v, 59));
                    default: ;
                endcase
            end
            default: begin
                if (sel_field >= dtfe_pkg::FIELD_SECONDS) begin
                    sel_field = dtfe_pkg::FIELD_YEAR;
                    done = 1'b1;
                end else begin
                    sel_field = sel_field + 3'd1;
                end
            end
        endcase
        view = '{sel_field, year_v, month_v, day_v, hours_v, minutes_v, seconds_v, done};
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_clock_view want;
        t_clock_view got;
        if (!i_rst_n) begin
            clear_clock();
            view_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_key(want);
                view_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_field_index, i_cur_year, i_cur_month, i_cur_day, i_cur_hours,
                        i_cur_minutes, i_cur_seconds, i_commit};
                if (view_q.size() == 0) begin
                    $error("Result beat arrived with no expected value waiting.");
                    mismatches++;
                end else begin
                    want = view_q.pop_front();
                    check_field("field_index", want.field, got.field);
                    check_field("cur_year", want.year, got.year);
                    check_field("cur_month", want.month, got.month);
                    check_field("cur_day", want.day, got.day);
                    check_field("cur_hours", want.hours, got.hours);
                    check_field("cur_minutes", want.minutes, got.minutes);
                    check_field("cur_seconds", want.seconds, got.seconds);
                    check_field("commit", want.commit, got.commit);
                end
            end
        end
        waiting = view_q.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the field editor: clock, reset, key stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = dtfe_pkg::KIND_LOAD;
    logic [6:0] load_year = '0;
    logic [3:0] load_month = '0;
    logic [4:0] load_day = '0;
    logic [4:0] load_hours = '0;
    logic [5:0] load_minutes = '0;
    logic [5:0] load_seconds = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] field_index;
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [4:0] cur_hours;
    logic [5:0] cur_minutes;
    logic [5:0] cur_seconds;
    logic       commit;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    always #1 clk = ~clk;

    date_time_field_editor dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_load_year    (load_year),
        .i_load_month   (load_month),
        .i_load_day     (load_day),
        .i_load_hours   (load_hours),
        .i_load_minutes (load_minutes),
        .i_load_seconds (load_seconds),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_field_index  (field_index),
        .o_cur_year     (cur_year),
        .o_cur_month    (cur_month),
        .o_cur_day      (cur_day),
        .o_cur_hours    (cur_hours),
        .o_cur_minutes  (cur_minutes),
        .o_cur_seconds  (cur_seconds),
        .o_commit       (commit)
    );

    dtfe_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (kind),
        .i_load_year    (load_year),
        .i_load_month   (load_month),
        .i_load_day     (load_day),
        .i_load_hours   (load_hours),
        .i_load_minutes (load_minutes),
        .i_load_seconds (load_seconds),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_field_index  (field_index),
        .i_cur_year     (cur_year),
        .i_cur_month    (cur_month),
        .i_cur_day      (cur_day),
        .i_cur_hours    (cur_hours),
        .i_cur_minutes  (cur_minutes),
        .i_cur_seconds  (cur_seconds),
        .i_commit       (commit),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    // A requested hold keeps the output stalled long enough for the editor to back up.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            out_ready <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic dtfe_pkg::t_item press(input dtfe_pkg::t_kind k);
        logic [63:0]     r;
        dtfe_pkg::t_item it;
        r = {$urandom, $urandom};
        it = r[34:0];
        it.kind = k;
        return it;
    endfunction

    function automatic dtfe_pkg::t_item load_item(input int y, input int m, input int d,
                                                  input int h, input int mi, input int s);
        dtfe_pkg::t_item it;
        it.kind         = dtfe_pkg::KIND_LOAD;
        it.load_year    = 7'(y);
        it.load_month   = 4'(m);
        it.load_day     = 5'(d);
        it.load_hours   = 5'(h);
        it.load_minutes = 6'(mi);
        it.load_seconds = 6'(s);
        return it;
    endfunction

    task automatic offer_key(input dtfe_pkg::t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= it.kind;
        load_year    <= it.load_year;
        load_month   <= it.load_month;
        load_day     <= it.load_day;
        load_hours   <= it.load_hours;
        load_minutes <= it.load_minutes;
        load_seconds <= it.load_seconds;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Mostly whole editing passes with random presses, mixed with loose key beats.
    task automatic random_keys(input int count);
        int sent;
        int presses;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(99) < 85) begin
                    offer_key(load_item($urandom_range(99), $urandom_range(12, 1),
                                        $urandom_range(31, 1), $urandom_range(23),
                                        $urandom_range(59), $urandom_range(59)));
                end else begin
                    offer_key(press(dtfe_pkg::KIND_LOAD));
                end
                sent++;
                for (int f = 0; f < 6; f++) begin
                    presses = $urandom_range(4);
                    repeat (presses) begin
                        offer_key(press($urandom_range(1) ? dtfe_pkg::KIND_TENS :
                                                            dtfe_pkg::KIND_UNITS));
                        sent++;
                    end
                    offer_key(press(dtfe_pkg::KIND_ACCEPT));
                    sent++;
                end
            end else begin
                offer_key(press(dtfe_pkg::t_kind'($urandom_range(3))));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_key(load_item(0, 0, 0, 0, 0, 0));
        offer_key(load_item(127, 15, 31, 31, 63, 63));
        offer_key(load_item(99, 12, 31, 23, 59, 59));
        // From the top of every field: one units wrap, one tens step, then accept.
        // The day starts beyond the length of November.
        for (int f = 0; f < 6; f++) begin
            offer_key(press(dtfe_pkg::KIND_UNITS));
            offer_key(press(dtfe_pkg::KIND_TENS));
            offer_key(press(dtfe_pkg::KIND_ACCEPT));
        end
        // Leap-year February on the tens path, then a tens step that lands on day zero.
        offer_key(load_item(96, 2, 29, 0, 0, 0));
        offer_key(press(dtfe_pkg::KIND_ACCEPT));
        offer_key(press(dtfe_pkg::KIND_ACCEPT));
        offer_key(press(dtfe_pkg::KIND_TENS));
        offer_key(load_item(97, 2, 20, 0, 0, 0));
        offer_key(press(dtfe_pkg::KIND_ACCEPT));
        offer_key(press(dtfe_pkg::KIND_ACCEPT));
        offer_key(press(dtfe_pkg::KIND_TENS));
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                    hold_req <= hold_req + 1;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 69;
                end
                default: begin
                    tx_idle_pct = 13;
                    rx_stall_pct <= 13;
                end
            endcase
            random_keys(190);
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
